// ===== hw/rtl/olrb_pkg.sv =====
`timescale 1ns / 1ps

package olrb_pkg;

  localparam int unsigned DepthDefault = 256;
  localparam logic [7:0]  MarkerReset  = 8'd35;

  // Operation codes of a request.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] push_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       is_marker;
    logic       available;
    logic       lost_pending;
  } rsp_t;

endpackage

// ===== hw/rtl/olrb_ram.sv =====
`timescale 1ns / 1ps

module olrb_ram #(
  parameter int unsigned DEPTH = olrb_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/overwriting_log_ring_buffer_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Signals                          | Handshake
// ----------+----------------------------------+-------------------------------
// request   | start, busy, req_i               | taken when start & !busy
// result    | rsp_strobe_o, rsp_o              | one cycle, strobe marks it
// marker    | marker_we_i, marker_wdata_i      | written when marker_we_i
//
// A request can be taken every cycle; its result appears in the cycle after, from
// the registered read of the byte memory, so results follow back to back.
// busy is always low: the memory has one write and one read port and no access
// of a request depends on the read of the one before it.
// Reset empties the ring at once (pointers, flags and marker byte); memory contents stay.
// The receiver cannot stall, so no result ever waits.
module overwriting_log_ring_buffer_unit #(
  parameter int unsigned DEPTH = olrb_pkg::DepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  olrb_pkg::req_t req_i,
  output logic           rsp_strobe_o,
  output olrb_pkg::rsp_t rsp_o,
  input  logic           marker_we_i,
  input  logic [7:0]     marker_wdata_i
);

  import olrb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_next(logic [AW-1:0] p);
    ring_next = (p == LastIdx) ? '0 : p + AW'(1);
  endfunction

  logic [AW-1:0] rptr_q, rptr_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic          full_q, full_d;
  logic          lost_q, lost_d;
  logic [7:0]    marker_char_q;

  logic          strobe_q;
  logic          pop_data_q, pop_data_d;
  logic          pop_mark_q, pop_mark_d;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] wnext;
  logic [7:0]    mem_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wnext  = ring_next(wptr_q);

  always_comb begin
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    full_d     = full_q;
    lost_d     = lost_q;
    mem_we     = 1'b0;
    mem_waddr  = wptr_q;
    pop_data_d = 1'b0;
    pop_mark_d = 1'b0;
    if (accept) begin
      unique case (req_i.op)
        OP_PUSH: begin
          mem_we = 1'b1;
          if (full_q) begin
            // Overwrite the oldest byte and drag the read pointer along.
            mem_waddr = rptr_q;
            rptr_d    = ring_next(rptr_q);
            wptr_d    = ring_next(rptr_q);
            lost_d    = 1'b1;
          end else begin
            mem_waddr = wptr_q;
            wptr_d    = wnext;
            full_d    = (wnext == rptr_q);
          end
        end
        OP_POP: begin
          if (lost_q) begin
            lost_d     = 1'b0;
            pop_mark_d = 1'b1;
          end else if (full_q || (rptr_q != wptr_q)) begin
            pop_data_d = 1'b1;
            full_d     = 1'b0;
            rptr_d     = ring_next(rptr_q);
          end
        end
        OP_CLEAR: begin
          rptr_d = '0;
          wptr_d = '0;
          full_d = 1'b0;
          lost_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q        <= '0;
      wptr_q        <= '0;
      full_q        <= 1'b0;
      lost_q        <= 1'b0;
      marker_char_q <= MarkerReset;
      strobe_q      <= 1'b0;
      pop_data_q    <= 1'b0;
      pop_mark_q    <= 1'b0;
    end else begin
      rptr_q     <= rptr_d;
      wptr_q     <= wptr_d;
      full_q     <= full_d;
      lost_q     <= lost_d;
      strobe_q   <= accept;
      pop_data_q <= pop_data_d;
      pop_mark_q <= pop_mark_d;
      if (marker_we_i) begin
        marker_char_q <= marker_wdata_i;
      end
    end
  end

  // The oldest byte is read on every request; only a data pop uses it.
  olrb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.push_byte),
    .re_i    (accept),
    .raddr_i (rptr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    rsp_o.read_byte    = pop_data_q ? mem_rdata : (pop_mark_q ? marker_char_q : 8'd0);
    rsp_o.read_valid   = pop_data_q || pop_mark_q;
    rsp_o.is_marker    = pop_mark_q;
    rsp_o.available    = full_q || (rptr_q != wptr_q);
    rsp_o.lost_pending = lost_q;
  end

  assign rsp_strobe_o = strobe_q;

  a_full_ptrs_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (rptr_q == wptr_q))
    else $error("full ring with differing pointers");

  a_lost_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q |-> full_q)
    else $error("loss marked while ring not full");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_strobe_o)
    else $error("request without result");

  a_marker_from_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_mark_q && strobe_q) |-> !lost_q || $past(full_q && lost_q))
    else $error("marker returned without a loss");

endmodule
